// File: hdl/ppghrd_pkg.sv
// Shared widths, constants and register indexes of the PPG heart-rate detector.
`timescale 1ns / 1ps

package ppghrd_pkg;

   localparam int IR_W    = 18;
   localparam int TIME_W  = 32;
   localparam int REFR_W  = 16;
   localparam int BPM_W   = 8;
   localparam int DC_W    = 34;
   localparam int CSR_W   = 18;
   localparam int CSR_IDX_W = 3;

   // dc_new = floor(dc * DC_KEEP / 2^16) + ir * DC_TAKE
   localparam int DC_FRAC_W = 16;
   localparam logic [DC_FRAC_W-1:0] DC_KEEP = 16'd62259;
   localparam logic [11:0] DC_TAKE = 12'd3277;

   // Rate = MS_PER_MIN / elapsed
   localparam int QUO_W = 16;
   localparam logic [QUO_W-1:0] MS_PER_MIN = 16'd60000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NO_FINGER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_DROP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BPM_MIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BPM_MAX    = 3'd4;

   // Register reset values
   localparam logic [IR_W-1:0]   RST_NO_FINGER  = 18'd5000;
   localparam logic [IR_W-1:0]   RST_BEAT_DROP  = 18'd20;
   localparam logic [REFR_W-1:0] RST_REFRACTORY = 16'd250;
   localparam logic [BPM_W-1:0]  RST_BPM_MIN    = 8'd20;
   localparam logic [BPM_W-1:0]  RST_BPM_MAX    = 8'd255;

endpackage

// File: hdl/ppghrd_dcmul.sv
// Bit-serial multiply of the DC estimate by the keep factor, scaled down by 2^16.
`timescale 1ns / 1ps

module ppghrd_dcmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ppghrd_pkg::DC_W-1:0] dc_value,
   output logic                       done,
   output logic [ppghrd_pkg::DC_W-1:0] product
);
   import ppghrd_pkg::*;

   localparam int CNT_W = $clog2(DC_FRAC_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DC_FRAC_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DC_FRAC_W-1:0] coef_ff, coef_in;
   logic [DC_W-1:0]      dc_ff, dc_in;
   logic [DC_W:0]        acc_ff, acc_in;
   logic [DC_W+1:0]      sum;

   // LSB-first shift-add; dropping the low bit each step gives an exact floor
   always_comb begin
      sum     = {1'b0, acc_ff} + (coef_ff[0] ? {2'b00, dc_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      coef_in = coef_ff;
      dc_in   = dc_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         coef_in = DC_KEEP;
         dc_in   = dc_value;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = sum[DC_W+1:1];
         coef_in = coef_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      coef_ff <= coef_in;
      dc_ff   <= dc_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[DC_W-1:0];  // below dc, fits DC_W bits

endmodule

// File: hdl/ppghrd_div.sv
// Restoring divider, one quotient bit per cycle: 60000 divided by elapsed ms.
`timescale 1ns / 1ps

module ppghrd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppghrd_pkg::TIME_W-1:0] divisor,
   output logic                          done,
   output logic [ppghrd_pkg::QUO_W-1:0]  quotient
);
   import ppghrd_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [QUO_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [QUO_W:0]    rem_sh;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[QUO_W-1]};
      fits    = {{(TIME_W-QUO_W-1){1'b0}}, rem_sh} >= dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvs_in  = divisor;
         dvd_in  = MS_PER_MIN;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the dividend prefix, so QUO_W bits hold it
         rem_in = fits ? QUO_W'(rem_sh - dvs_ff[QUO_W:0]) : rem_sh[QUO_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/ppg_heart_rate_detector.sv
// Top level of the PPG heart-rate detector: control sequencer, state and ports.
// Sample path: accepted in S_IDLE; a no-finger sample goes straight to S_FIN, other
//   samples pass S_DC (DC multiply), S_TEST and, on a beat, S_DIV (rate divide) first.
// One sample at a time, accepted only in S_IDLE, so the pace is set by the bit-serial DC
//   multiply and the bit-serial rate divider; a new sample is taken while a result waits.
// Reset (synchronous, active high): registers to defaults, DC, last beat, average 0.
`timescale 1ns / 1ps

module ppg_heart_rate_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample beats
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [55:0]                           req_tdata,  // [17:0] ir_level, [49:18] now_ms
   // result beats
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,  // [7:0] avg_bpm, [8] beat_seen,
                                                             // [9] bpm_accepted
   // register writes
   input  logic                                  csr_wen,
   input  logic [ppghrd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppghrd_pkg::CSR_W-1:0]          csr_wdata
);
   import ppghrd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DC   = 5'b00010,
      S_TEST = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [IR_W-1:0]   nofinger_ff, nofinger_in;
   logic [IR_W-1:0]   drop_ff, drop_in;
   logic [REFR_W-1:0] refr_ff, refr_in;
   logic [BPM_W-1:0]  bpm_min_ff, bpm_min_in;
   logic [BPM_W-1:0]  bpm_max_ff, bpm_max_in;

   // architectural state
   logic [DC_W-1:0]   dc_ff, dc_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [BPM_W-1:0]  avg_ff, avg_in;

   // per-sample working registers
   logic [IR_W-1:0]   ir_ff, ir_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              nf_ff, nf_in;
   logic              beat_ff, beat_in;
   logic [DC_W-1:0]   dcn_ff, dcn_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   // serial units
   logic              mul_start, mul_done;
   logic [DC_W-1:0]   mul_prod;
   logic              div_start, div_done;
   logic [QUO_W-1:0]  bpm;

   logic              req_take;
   logic              slot_free;
   logic [29:0]       take_prod;
   logic [DC_W:0]     limit;
   logic              beat_now;
   logic              bpm_ok;
   logic [BPM_W+1:0]  avg_sum;
   logic [BPM_W-1:0]  avg_next;

   ppghrd_dcmul u_dcmul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .dc_value (dc_ff),
      .done     (mul_done),
      .product  (mul_prod)
   );

   ppghrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (bpm)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      // datapath terms
      take_prod = 30'(ir_ff) * 30'(DC_TAKE);
      limit     = {(({1'b0, ir_ff}) + ({1'b0, drop_ff})), {DC_FRAC_W{1'b0}}};
      beat_now  = ({1'b0, dcn_ff} > limit) &&
                  (elapsed_ff > {{(TIME_W-REFR_W){1'b0}}, refr_ff});
      bpm_ok    = beat_ff && (bpm < {{(QUO_W-BPM_W){1'b0}}, bpm_max_ff}) &&
                  (bpm > {{(QUO_W-BPM_W){1'b0}}, bpm_min_ff});
      // (3*avg + bpm) / 4; bpm is below bpm_max here so its low byte is exact
      avg_sum   = ({2'b00, avg_ff} << 1) + {2'b00, avg_ff} + {2'b00, bpm[BPM_W-1:0]};
      if (nf_ff) begin
         avg_next = '0;
      end else if (bpm_ok) begin
         avg_next = (avg_ff == '0) ? bpm[BPM_W-1:0] : avg_sum[BPM_W+1:2];
      end else begin
         avg_next = avg_ff;
      end

      // defaults
      state_in     = state_ff;
      nofinger_in  = nofinger_ff;
      drop_in      = drop_ff;
      refr_in      = refr_ff;
      bpm_min_in   = bpm_min_ff;
      bpm_max_in   = bpm_max_ff;
      dc_in        = dc_ff;
      last_in      = last_ff;
      avg_in       = avg_ff;
      ir_in        = ir_ff;
      now_in       = now_ff;
      nf_in        = nf_ff;
      beat_in      = beat_ff;
      dcn_in       = dcn_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;

      if (csr_wen) begin
         unique case (csr_index)
            CSR_NO_FINGER:  nofinger_in = csr_wdata[IR_W-1:0];
            CSR_BEAT_DROP:  drop_in     = csr_wdata[IR_W-1:0];
            CSR_REFRACTORY: refr_in     = csr_wdata[REFR_W-1:0];
            CSR_BPM_MIN:    bpm_min_in  = csr_wdata[BPM_W-1:0];
            CSR_BPM_MAX:    bpm_max_in  = csr_wdata[BPM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ir_in   = req_tdata[IR_W-1:0];
               now_in  = req_tdata[IR_W+TIME_W-1:IR_W];
               nf_in   = req_tdata[IR_W-1:0] < nofinger_ff;
               beat_in = 1'b0;
               if (req_tdata[IR_W-1:0] < nofinger_ff) begin
                  state_in = S_FIN;
               end else begin
                  mul_start = 1'b1;
                  state_in  = S_DC;
               end
            end
         end
         S_DC: begin
            if (mul_done) begin
               // sum stays at or below max(dc, ir << 16)
               dcn_in     = mul_prod + DC_W'(take_prod);
               elapsed_in = now_ff - last_ff;
               state_in   = S_TEST;
            end
         end
         S_TEST: begin
            beat_in = beat_now;
            if (beat_now) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               avg_in       = avg_next;
               dc_in        = nf_ff ? '0 : dcn_ff;
               last_in      = beat_ff ? now_ff : last_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, bpm_ok, beat_ff, avg_next};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nofinger_ff  <= RST_NO_FINGER;
         drop_ff      <= RST_BEAT_DROP;
         refr_ff      <= RST_REFRACTORY;
         bpm_min_ff   <= RST_BPM_MIN;
         bpm_max_ff   <= RST_BPM_MAX;
         dc_ff        <= '0;
         last_ff      <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nofinger_ff  <= nofinger_in;
         drop_ff      <= drop_in;
         refr_ff      <= refr_in;
         bpm_min_ff   <= bpm_min_in;
         bpm_max_ff   <= bpm_max_in;
         dc_ff        <= dc_in;
         last_ff      <= last_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ir_ff       <= ir_in;
      now_ff      <= now_in;
      nf_ff       <= nf_in;
      beat_ff     <= beat_in;
      dcn_ff      <= dcn_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/ppghrd_checker.sv
// Port-level checks on the PPG heart-rate detector, bound to the top level.
`timescale 1ns / 1ps

module ppghrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one sample at a time: no second accept right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted while another is in work");

   // an averaged rate only comes with a beat
   a_acc_needs_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && !rsp_tdata[8]))
      else $error("bpm_accepted without beat_seen");

   // an averaged rate leaves a nonzero average
   a_acc_avg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[7:0] != 8'd0)
      else $error("zero average after accepted rate");

   // padding bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:10] == 6'd0)
      else $error("nonzero padding in result beat");

endmodule

bind ppg_heart_rate_detector ppghrd_checker u_ppghrd_checker (.*);
